// File: design/pol_pkg.sv
// ----------------------------------------------------------------------------
// Positional ordered list - shared definitions
// Sizes, request and status codes, and the result record types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

    // list capacity (1..31; entry_count is CNT_OUT_W bits wide)
    localparam int DEPTH     = 16;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 5;
    localparam int ST_W      = 2;

    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    // width for position / count compares, with room for count + 1
    localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_POS   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0]    element;
        logic                        element_valid;
        logic                        last;
        logic        [CNT_OUT_W-1:0] entry_count;
        logic        [ST_W-1:0]      status;
    } t_rsp;

    typedef struct packed {
        logic push;
        t_rsp rsp;
    } t_push;

endpackage

`default_nettype wire

// File: design/pol_if.sv
// ----------------------------------------------------------------------------
// Positional ordered list - channel interfaces
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pol_req_if;
    logic                               valid;
    logic                               ready;
    logic        [pol_pkg::OP_W-1:0]    op;
    logic signed [pol_pkg::DATA_W-1:0]  value;
    logic        [pol_pkg::POS_W-1:0]   position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface pol_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [pol_pkg::DATA_W-1:0]   element;
    logic                                element_valid;
    logic                                last;
    logic        [pol_pkg::CNT_OUT_W-1:0] entry_count;
    logic        [pol_pkg::ST_W-1:0]     status;

    modport source (output valid, output element, output element_valid, output last,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input element, input element_valid, input last,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

// File: design/pol_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/pol_rsp_reg.sv
// ----------------------------------------------------------------------------
// Positional ordered list - result register
// One-entry output register that decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pol_rsp_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pol_pkg::t_push i_push,
    output      logic           o_can_push,
    pol_rsp_if.source           o_rsp
);

    import pol_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    assign o_can_push = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.push) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_rsp <= i_push.rsp;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.element       = r_rsp.element;
    assign o_rsp.element_valid = r_rsp.element_valid;
    assign o_rsp.last          = r_rsp.last;
    assign o_rsp.entry_count   = r_rsp.entry_count;
    assign o_rsp.status        = r_rsp.status;

endmodule

`default_nettype wire

// File: design/positional_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// Positional ordered list unit
// Ordered list of signed words in a RAM, with positional insert/delete and dump.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (op, value, position); o_rsp returns results.
//   Inserts, deletes and unused ops give one result (count and status);
//   a dump gives one result per entry, front first, last set on the final
//   one, or a single empty result when the list is empty.
//   One request is worked on at a time; i_req.ready is high while the
//   sequencer is idle, also while a finished result waits in the output
//   register.
//   Inserts and deletes move one entry per cycle through the single RAM
//   port pair; a dump sends one entry per cycle while the receiver takes
//   them. The sequencer is back to idle, ready for the next request, in
//   the cycle its result is registered.
//   A stalled receiver holds the output register; a dump then pauses with
//   its read data held in the RAM output.
//   Synchronous reset empties the list at once; no clearing pass is run,
//   entries at or above the count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pol_req_if.sink   i_req,
    pol_rsp_if.source o_rsp
);

    import pol_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_DUMP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_occ,      n_occ;
    logic [CNT_W-1:0]  r_ptr,      n_ptr;
    logic [CNT_W-1:0]  r_lim,      n_lim;
    logic              r_pend,     n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [DATA_W-1:0] r_value,    n_value;
    logic [ST_W-1:0]   r_status,   n_status;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              can_push;
    t_push             w_push;

    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  ptr_dec;
    logic [CMP_W-1:0]  occ_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  pos_m1;
    logic [CNT_OUT_W-1:0] cnt_out;

    assign ptr_inc = r_ptr + 1'b1;
    assign ptr_dec = r_ptr - 1'b1;
    assign occ_ext = CMP_W'(r_occ);
    assign pos_ext = CMP_W'(i_req.position);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign cnt_out = CNT_OUT_W'(r_occ);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_ptr       = r_ptr;
        n_lim       = r_lim;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_value     = r_value;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        w_push      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value  = i_req.value;
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    unique case (i_req.op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                            if (r_occ == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (i_req.op == OP_INS_POS &&
                                         (pos_ext == '0 ||
                                          pos_ext > occ_ext + CMP_W'(1))) begin
                                n_status = ST_POS;
                                n_state  = S_DONE;
                            end else begin
                                n_ptr   = r_occ;
                                n_state = S_INS;
                                if (i_req.op == OP_INS_FRONT) begin
                                    n_lim = '0;
                                end else if (i_req.op == OP_INS_BACK) begin
                                    n_lim = r_occ;
                                end else begin
                                    n_lim = CNT_W'(pos_m1);
                                end
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else if (i_req.op == OP_DEL_POS &&
                                         (pos_ext == '0 || pos_ext > occ_ext)) begin
                                n_status = ST_POS;
                                n_state  = S_DONE;
                            end else begin
                                // read pointer starts one past the removed entry
                                n_state = S_DEL;
                                if (i_req.op == OP_DEL_FRONT) begin
                                    n_ptr = CNT_W'(1);
                                end else if (i_req.op == OP_DEL_BACK) begin
                                    n_ptr = r_occ;
                                end else begin
                                    n_ptr = CNT_W'(pos_ext);
                                end
                            end
                        end
                        OP_DUMP: begin
                            n_ptr   = '0;
                            n_state = (r_occ == '0) ? S_DONE : S_DUMP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_INS: begin
                // move entries up by one, top first; each write lands in the cycle after its read
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_ptr > r_lim) begin
                    ram_re      = 1'b1;
                    ram_raddr   = ptr_dec[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr[ADDR_W-1:0];
                    n_ptr       = ptr_dec;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_lim[ADDR_W-1:0];
                        ram_wdata = r_value;
                        n_occ     = r_occ + 1'b1;
                        n_state   = S_DONE;
                    end
                end
            end

            S_DEL: begin
                // move entries down by one, bottom first
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_ptr < r_occ) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_ptr[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = ptr_dec[ADDR_W-1:0];
                    n_ptr       = ptr_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_occ   = r_occ - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end

            S_DUMP: begin
                // r_pend: RAM output holds entry r_ptr-1, waiting to be sent
                if (r_pend && can_push) begin
                    w_push.push              = 1'b1;
                    w_push.rsp.element       = ram_rdata;
                    w_push.rsp.element_valid = 1'b1;
                    w_push.rsp.last          = (r_ptr == r_occ);
                    w_push.rsp.entry_count   = cnt_out;
                    w_push.rsp.status        = ST_OK;
                end
                if (r_ptr < r_occ && (!r_pend || can_push)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr[ADDR_W-1:0];
                    n_ptr     = ptr_inc;
                    n_pend    = 1'b1;
                end else if (r_pend && can_push) begin
                    n_pend = 1'b0;
                end
                if (r_pend && can_push && r_ptr == r_occ) begin
                    n_state = S_IDLE;
                end
            end

            S_DONE: begin
                if (can_push) begin
                    w_push.push              = 1'b1;
                    w_push.rsp.element       = '0;
                    w_push.rsp.element_valid = 1'b0;
                    w_push.rsp.last          = 1'b1;
                    w_push.rsp.entry_count   = cnt_out;
                    w_push.rsp.status        = r_status;
                    n_state                  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_lim       <= n_lim;
        r_pend_addr <= n_pend_addr;
        r_value     <= n_value;
        r_status    <= n_status;
    end

    pol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pol_rsp_reg u_rsp_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_can_push (can_push),
        .o_rsp      (o_rsp)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_occ != $past(r_occ)) |->
            (r_occ == $past(r_occ) + 1'b1 || r_occ == $past(r_occ) - 1'b1))
        else $error("entry count moved by more than one");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("RAM written while idle");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("shift reads the entry it writes");

    a_elem_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.push && w_push.rsp.element_valid) |-> (r_state == S_DUMP && r_pend))
        else $error("list entry sent outside a dump");
`endif

endmodule

`default_nettype wire
